/* rtl/udw_pkg.sv */
// Shared types, range tables and the column classifier for the display width block.
package udw_pkg;

    localparam int CP_BITS     = 21;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_BITS    = 16;
    localparam int ZERO_RANGES = 8;
    localparam int WIDE_RANGES = 17;

    // Lead byte classes
    localparam logic [7:0] LEAD2_MIN = 8'hC0;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD4_MIN = 8'hF0;

    typedef logic [CP_BITS-1:0] cp_t;

    // One decoded event handed from the decoder to the accumulator
    typedef struct packed {
        logic has_cp;
        cp_t  cp;
        logic last;
    } cp_event_t;

    localparam cp_t ZERO_LO [ZERO_RANGES] = '{
        21'h00000, 21'h0007F, 21'h00300, 21'h0200B,
        21'h020D0, 21'h0FE00, 21'h0FE20, 21'hE0100
    };
    localparam cp_t ZERO_HI [ZERO_RANGES] = '{
        21'h0001F, 21'h0009F, 21'h0036F, 21'h0200F,
        21'h020FF, 21'h0FE0F, 21'h0FE2F, 21'hE01EF
    };
    localparam cp_t WIDE_LO [WIDE_RANGES] = '{
        21'h01100, 21'h02329, 21'h02E80, 21'h03040, 21'h03250, 21'h04E00,
        21'h0A960, 21'h0AC00, 21'h0F900, 21'h0FE10, 21'h0FE30, 21'h0FF01,
        21'h0FFE0, 21'h1B000, 21'h1F200, 21'h1F300, 21'h20000
    };
    localparam cp_t WIDE_HI [WIDE_RANGES] = '{
        21'h0115F, 21'h0232A, 21'h0303E, 21'h03247, 21'h04DBF, 21'h0A4C6,
        21'h0A97C, 21'h0D7A3, 21'h0FAFF, 21'h0FE19, 21'h0FE6B, 21'h0FF60,
        21'h0FFE6, 21'h1B001, 21'h1F251, 21'h1F64F, 21'h3FFFD
    };

    // Columns taken by one code point: zero-width test first, then wide
    function automatic logic [1:0] cp_cols(input cp_t cp);
        logic is_zero;
        logic is_wide;
        is_zero = 1'b0;
        is_wide = 1'b0;
        for (int i = 0; i < ZERO_RANGES; i++) begin
            if (cp >= ZERO_LO[i] && cp <= ZERO_HI[i]) begin
                is_zero = 1'b1;
            end
        end
        for (int i = 0; i < WIDE_RANGES; i++) begin
            if (cp >= WIDE_LO[i] && cp <= WIDE_HI[i]) begin
                is_wide = 1'b1;
            end
        end
        if (is_zero) begin
            return 2'd0;
        end else if (is_wide) begin
            return 2'd2;
        end
        return 2'd1;
    endfunction

endpackage

/* rtl/udw_front.sv */
// Front end: accepts string bytes and assembles UTF-8 code points.
module udw_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // byte_value
    input  logic                 s_tlast,   // last_byte
    input  logic                 q_full,
    output logic                 q_push,
    output udw_pkg::cp_event_t   q_event
);
    import udw_pkg::*;

    logic [1:0] pending_reg, pending_next;
    cp_t        accum_reg, accum_next;
    logic       accept;
    logic       emit;
    cp_t        cp_new;
    logic [1:0] pend_new;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // Decode the byte against the current sequence state
    always_comb begin
        cp_new   = accum_reg;
        pend_new = pending_reg;
        emit     = 1'b0;
        if (pending_reg == 2'd0) begin
            if (s_tdata < LEAD2_MIN) begin
                cp_new = CP_BITS'(s_tdata);
                emit   = 1'b1;
            end else if (s_tdata < LEAD3_MIN) begin
                cp_new   = CP_BITS'(s_tdata[4:0]);
                pend_new = 2'd1;
            end else if (s_tdata < LEAD4_MIN) begin
                cp_new   = CP_BITS'(s_tdata[3:0]);
                pend_new = 2'd2;
            end else begin
                cp_new   = CP_BITS'(s_tdata[2:0]);
                pend_new = 2'd3;
            end
        end else begin
            cp_new   = {accum_reg[CP_BITS-7:0], s_tdata[5:0]};
            pend_new = pending_reg - 2'd1;
            emit     = (pend_new == 2'd0);
        end
        // A truncated sequence still counts what was assembled
        if (s_tlast && pend_new != 2'd0) begin
            emit = 1'b1;
        end
    end

    // Clear the sequence state at the end of each string
    always_comb begin
        pending_next = pending_reg;
        accum_next   = accum_reg;
        if (accept) begin
            if (s_tlast) begin
                pending_next = 2'd0;
                accum_next   = '0;
            end else begin
                pending_next = pend_new;
                accum_next   = cp_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 2'd0;
            accum_reg   <= '0;
        end else begin
            pending_reg <= pending_next;
            accum_reg   <= accum_next;
        end
    end

    // Hand a code point or end-of-string marker to the queue
    assign q_push         = accept && (emit || s_tlast);
    assign q_event.has_cp = emit;
    assign q_event.cp     = cp_new;
    assign q_event.last   = s_tlast;

endmodule

/* rtl/udw_queue.sv */
// Short queue of decoded code point items between the front and back ends.
module udw_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  udw_pkg::cp_event_t   push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output udw_pkg::cp_event_t   head
);
    import udw_pkg::*;

    cp_event_t              slots_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]   count_reg, count_next;

    assign full      = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slots_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("queue count out of range");
    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");
`endif

endmodule

/* rtl/udw_back.sv */
// Back end: classifies code points, keeps the saturating sum and holds the result.
module udw_back #(
    parameter int WIDTH_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_not_empty,
    input  udw_pkg::cp_event_t   q_head,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // total_width
    output logic                 m_tuser    // width_saturated
);
    import udw_pkg::*;

    localparam logic [WIDTH_BITS:0] SUM_MAX = {1'b0, {WIDTH_BITS{1'b1}}};

    logic [WIDTH_BITS-1:0] sum_reg, sum_next;
    logic                  sat_reg, sat_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_BITS-1:0]   out_data_reg, out_data_next;
    logic                  out_sat_reg, out_sat_next;
    logic [1:0]            cols;
    logic [WIDTH_BITS:0]   sum_add;
    logic [WIDTH_BITS-1:0] sum_new;
    logic                  sat_new;
    logic [31:0]           sum_wide;

    // Take the head item unless its result would overwrite a waiting one
    assign q_pop = q_not_empty && (!q_head.last || !out_valid_reg || m_tready);

    // Classify and add with saturation
    always_comb begin
        cols    = q_head.has_cp ? cp_cols(q_head.cp) : 2'd0;
        sum_add = {1'b0, sum_reg} + (WIDTH_BITS + 1)'(cols);
        sum_new = sum_reg;
        sat_new = sat_reg;
        if (q_head.has_cp) begin
            if (sum_add >= SUM_MAX) begin
                sum_new = SUM_MAX[WIDTH_BITS-1:0];
                sat_new = 1'b1;
            end else begin
                sum_new = sum_add[WIDTH_BITS-1:0];
            end
        end
        sum_wide = 32'(sum_new);
    end

    // Update the sum and the output register
    always_comb begin
        sum_next       = sum_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_sat_next   = out_sat_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (q_pop) begin
            if (q_head.last) begin
                sum_next       = '0;
                sat_next       = 1'b0;
                out_valid_next = 1'b1;
                out_data_next  = sum_wide[OUT_BITS-1:0];
                out_sat_next   = sat_new;
            end else begin
                sum_next = sum_new;
                sat_next = sat_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            sum_reg       <= sum_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        out_sat_reg  <= out_sat_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_sat_reg;

`ifndef SYNTHESIS
    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_sat_reg) |->
            out_data_reg == 16'(32'(SUM_MAX[WIDTH_BITS-1:0])))
        else $error("saturated result does not hold the maximum");
    a_sum_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (sum_reg == SUM_MAX[WIDTH_BITS-1:0]) |-> sat_reg)
        else $error("sum at maximum without saturation flag");
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_head.last) |=> (sum_reg == '0 && !sat_reg && out_valid_reg))
        else $error("string end did not clear the sum and post a result");
`endif

endmodule

/* rtl/utf8_display_width.sv */
// Top level of the UTF-8 string display width block.
//
// Usage:
//   The input channel (s_*) takes one string byte per item in s_tdata, with
//   s_tlast high on the final byte. Empty strings are not sent.
//   The result channel (m_*) gives one item per string: the saturated display
//   width in m_tdata and the saturation flag in m_tuser.
// Throughput: one byte per cycle; the decoder takes a byte every cycle while
//   the four-entry item queue has room.
// Result path: the last byte's item is written into the item queue; when the
//   back end pops it, the output register is loaded and m_tvalid rises.
// Stall: while a result waits on m_tready the accumulator keeps draining
//   bytes of the next string; only that string's last item waits, and the
//   input stalls once the queue fills.
// Reset: aresetn low clears the decoder, queue, sum and output valid; the
//   block is ready the cycle after reset is released.
module utf8_display_width #(
    parameter int WIDTH_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // byte_value
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // total_width
    output logic        m_tuser    // width_saturated
);
    import udw_pkg::*;

    logic      q_full;
    logic      q_push;
    logic      q_pop;
    logic      q_not_empty;
    cp_event_t q_in;
    cp_event_t q_head;

    udw_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_event  (q_in)
    );

    udw_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    udw_back #(
        .WIDTH_BITS (WIDTH_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

/* tb/utf8_display_width_tb.sv */
// Self-checking testbench for the UTF-8 string display width block.
module utf8_display_width_tb;
    import udw_pkg::*;

    localparam int WIDTH_BITS   = 16;
    localparam int SUM_MAX      = (1 << WIDTH_BITS) - 1;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASE_ITEMS  = 263;
    localparam int MAX_PRINTS   = 30;
    localparam int N_ZERO       = 8;
    localparam int N_WIDE       = 17;

    // Column class range bounds
    localparam logic [20:0] ZW_LO [N_ZERO] = '{
        21'h00000, 21'h0007F, 21'h00300, 21'h0200B,
        21'h020D0, 21'h0FE00, 21'h0FE20, 21'hE0100
    };
    localparam logic [20:0] ZW_HI [N_ZERO] = '{
        21'h0001F, 21'h0009F, 21'h0036F, 21'h0200F,
        21'h020FF, 21'h0FE0F, 21'h0FE2F, 21'hE01EF
    };
    localparam logic [20:0] FW_LO [N_WIDE] = '{
        21'h01100, 21'h02329, 21'h02E80, 21'h03040, 21'h03250, 21'h04E00,
        21'h0A960, 21'h0AC00, 21'h0F900, 21'h0FE10, 21'h0FE30, 21'h0FF01,
        21'h0FFE0, 21'h1B000, 21'h1F200, 21'h1F300, 21'h20000
    };
    localparam logic [20:0] FW_HI [N_WIDE] = '{
        21'h0115F, 21'h0232A, 21'h0303E, 21'h03247, 21'h04DBF, 21'h0A4C6,
        21'h0A97C, 21'h0D7A3, 21'h0FAFF, 21'h0FE19, 21'h0FE6B, 21'h0FF60,
        21'h0FFE6, 21'h1B001, 21'h1F251, 21'h1F64F, 21'h3FFFD
    };

    // Tracks the decode of each string and the widths still owed by the block
    class string_width_board;
        int unsigned     pend_cont;
        logic [20:0]     cp_acc;
        int unsigned     col_sum;
        bit              sat_flag;
        logic [15:0]     owed_width[$];
        bit              owed_sat[$];
        int              errors;
        int              strings_checked;
        int              saturated_seen;

        function new();
            errors = 0;
            strings_checked = 0;
            saturated_seen = 0;
            clear_string();
        endfunction

        function void clear_string();
            pend_cont = 0;
            cp_acc = '0;
            col_sum = 0;
            sat_flag = 0;
        endfunction

        // Zero-width ranges win over wide ranges
        function int unsigned cols_of(logic [20:0] c);
            for (int i = 0; i < N_ZERO; i++) begin
                if (c >= ZW_LO[i] && c <= ZW_HI[i]) return 0;
            end
            for (int i = 0; i < N_WIDE; i++) begin
                if (c >= FW_LO[i] && c <= FW_HI[i]) return 2;
            end
            return 1;
        endfunction

        // Add with saturation at the sum maximum
        function void add_cols(logic [20:0] c);
            int unsigned s;
            s = col_sum + cols_of(c);
            if (s >= SUM_MAX) begin
                s = SUM_MAX;
                sat_flag = 1;
            end
            col_sum = s;
        endfunction

        function void take_byte(logic [7:0] b, logic last);
            if (pend_cont == 0) begin
                if (b < LEAD2_MIN) begin
                    add_cols({13'd0, b});
                end else if (b < LEAD3_MIN) begin
                    cp_acc = {16'd0, b[4:0]};
                    pend_cont = 1;
                end else if (b < LEAD4_MIN) begin
                    cp_acc = {17'd0, b[3:0]};
                    pend_cont = 2;
                end else begin
                    cp_acc = {18'd0, b[2:0]};
                    pend_cont = 3;
                end
            end else begin
                cp_acc = {cp_acc[14:0], b[5:0]};
                pend_cont--;
                if (pend_cont == 0) add_cols(cp_acc);
            end
            // Close the string: count a cut-off sequence as assembled so far
            if (last) begin
                if (pend_cont != 0) add_cols(cp_acc);
                owed_width.push_back(col_sum[15:0]);
                owed_sat.push_back(sat_flag);
                clear_string();
            end
        endfunction

        function void check_width(logic [15:0] w, logic s);
            logic [15:0] ew;
            bit          es;
            if (owed_width.size() == 0) begin
                errors++;
                if (errors <= MAX_PRINTS)
                    $display("%0t: unexpected result, got width %0d sat %0b", $time, w, s);
                return;
            end
            ew = owed_width.pop_front();
            es = owed_sat.pop_front();
            strings_checked++;
            if (s === 1'b1) saturated_seen++;
            if (w !== ew || s !== es) begin
                errors++;
                if (errors <= MAX_PRINTS)
                    $display("%0t: width mismatch, expected %0d sat %0b, got %0d sat %0b",
                             $time, ew, es, w, s);
            end
        endfunction

        function int outstanding();
            return owed_width.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;

    string_width_board board = new();
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          cycles = 0;
    int          bytes_sent = 0;
    logic [7:0]  str_bytes[$];

    utf8_display_width #(
        .WIDTH_BITS(WIDTH_BITS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Randomize result back-pressure
    always @(negedge aclk) begin
        m_tready <= (sink_stall_pct == 0) || ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Check results and guard against a hang
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) board.check_width(m_tdata, m_tuser);
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, board.outstanding());
            $display("utf8_display_width regression: fail");
            $finish;
        end
    end

    // Offer one byte, hold until accepted; called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.take_byte(b, last);
        bytes_sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic send_string();
        for (int i = 0; i < str_bytes.size(); i++)
            send_byte(str_bytes[i], i == str_bytes.size() - 1);
    endtask

    task automatic wait_drained();
        while (board.outstanding() != 0) @(negedge aclk);
    endtask

    // Append the UTF-8 form of a code point; code point zero becomes 1
    function automatic void push_cp(logic [20:0] c);
        if (c == 0) c = 21'd1;
        if (c < 21'h80) begin
            str_bytes.push_back(c[7:0]);
        end else if (c < 21'h800) begin
            str_bytes.push_back({3'b110, c[10:6]});
            str_bytes.push_back({2'b10, c[5:0]});
        end else if (c < 21'h10000) begin
            str_bytes.push_back({4'b1110, c[15:12]});
            str_bytes.push_back({2'b10, c[11:6]});
            str_bytes.push_back({2'b10, c[5:0]});
        end else begin
            str_bytes.push_back({5'b11110, c[20:18]});
            str_bytes.push_back({2'b10, c[17:12]});
            str_bytes.push_back({2'b10, c[11:6]});
            str_bytes.push_back({2'b10, c[5:0]});
        end
    endfunction

    // Pick a code point just around a range boundary
    function automatic logic [20:0] edge_cp();
        int          k;
        logic [20:0] c;
        k = $urandom_range(0, 2 * (N_ZERO + N_WIDE) - 1);
        if (k < N_ZERO)                   c = ZW_LO[k];
        else if (k < 2 * N_ZERO)          c = ZW_HI[k - N_ZERO];
        else if (k < 2 * N_ZERO + N_WIDE) c = FW_LO[k - 2 * N_ZERO];
        else                              c = FW_HI[k - 2 * N_ZERO - N_WIDE];
        case ($urandom_range(0, 2))
            0: c = c - 21'd1;
            1: c = c + 21'd1;
            default: ;
        endcase
        return c;
    endfunction

    // Build one random string: mostly well-formed, some noise, some cut short
    function automatic void make_string();
        int n;
        int mode;
        int cut;
        str_bytes.delete();
        n = $urandom_range(1, 10);
        mode = $urandom_range(0, 99);
        if (mode >= 80 && mode < 90) begin
            for (int i = 0; i < n; i++) str_bytes.push_back(8'($urandom_range(1, 255)));
            return;
        end
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: str_bytes.push_back(8'($urandom_range(1, 127)));
                3:       str_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
                4, 5, 6: push_cp(edge_cp());
                7:       push_cp(21'($urandom_range(0, 21'h10FFFF)));
                8:       push_cp(21'($urandom_range(21'h4E00, 21'h9FFF)));
                default: push_cp(21'($urandom_range(21'h10000, 21'h1FFFFF)));
            endcase
        end
        // Drop one or two tail bytes, so the string can end inside a sequence
        if (mode >= 90 && str_bytes.size() > 2) begin
            cut = $urandom_range(1, 2);
            repeat (cut) void'(str_bytes.pop_back());
        end
    endfunction

    task automatic run_random_phase(input int idle_pct, input int stall_pct);
        int start;
        src_idle_pct = idle_pct;
        sink_stall_pct = stall_pct;
        start = bytes_sent;
        while (bytes_sent - start < PHASE_ITEMS) begin
            make_string();
            send_string();
            // Now and then hold the input until every result is back
            if ($urandom_range(0, 29) == 0) wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tlast  = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed strings: field extremes, each lead length, odd cases
        send_byte(8'h01, 1'b1);
        send_byte(8'hFF, 1'b1);
        // stray continuations and DEL
        str_bytes = '{8'h80, 8'hBF, 8'h7F, 8'h20};
        send_string();
        // two-byte: plain letter, combining mark, continuation of any value
        str_bytes = '{8'hC3, 8'hA9, 8'hCC, 8'h81, 8'hC3, 8'h41};
        send_string();
        // three-byte: wide ideograph, zero-width space, fullwidth form
        str_bytes = '{8'hE4, 8'hB8, 8'h80, 8'hE2, 8'h80, 8'h8B, 8'hEF, 8'hBC, 8'h81};
        send_string();
        // four-byte: wide plane, variation selector supplement
        str_bytes = '{8'hF0, 8'hA0, 8'h80, 8'h80, 8'hF3, 8'hA0, 8'h84, 8'h80};
        send_string();
        // cut off after two bytes of a three-byte sequence
        str_bytes = '{8'hE4, 8'hB8};
        send_string();
        wait_drained();

        run_random_phase(0, 0);
        run_random_phase(77, 0);
        run_random_phase(0, 77);
        run_random_phase(26, 26);

        src_idle_pct = 0;
        sink_stall_pct = 0;
        wait_drained();
        repeat (8) @(negedge aclk);

        $display("Covered %0d bytes in %0d strings (%0d saturated), with idle and stall mixes.",
                 bytes_sent, board.strings_checked, board.saturated_seen);
        if (board.errors == 0) begin
            $display("utf8_display_width regression: pass");
        end else begin
            $display("%0d mismatches", board.errors);
            $display("utf8_display_width regression: fail");
        end
        $finish;
    end

endmodule
